>>> rtl/core/tlpp_pkg.sv
`default_nettype none

package tlpp_pkg;

  // Field and register widths
  localparam int LVL_W   = 16;
  localparam int SCR_W   = 10;
  localparam int POSX_W  = 11;
  localparam int POSY_W  = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;
  localparam int PROD_W  = SCR_W + LVL_W;
  localparam int SUM_W   = LVL_W + 1;

  // Quotient of width*ea/(ea+eb) never exceeds width, so it fits SCR_W bits
  localparam int DIV_STEPS = SCR_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Default vertical span
  localparam int C_SPAN_DEF = 2048;

  // Register reset values
  localparam logic [LVL_W-1:0] FLOOR_RST = 16'h0200;
  localparam logic [LVL_W-1:0] PRESS_RST = 16'h0C00;
  localparam logic [SCR_W-1:0] WIDTH_RST = 10'd320;
  localparam logic [SCR_W-1:0] HEIGHT_RST = 10'd240;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FLOOR_A  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FLOOR_B  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FLOOR_C  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PRESS    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd5;

  // Sequencer program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] STEP_EXCESS = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_Y  = 4'd2;
  localparam logic [PC_W-1:0] STEP_CALC_Y = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL_X  = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_IN = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV    = 4'd6;
  localparam logic [PC_W-1:0] STEP_CALC_X = 4'd7;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd8;
  localparam logic [PC_W-1:0] STEP_LAST   = STEP_EMIT;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXCESS,
    OP_MUL_Y,
    OP_CALC_Y,
    OP_MUL_X,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CALC_X,
    OP_EMIT
  } dp_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_POLL,
    JC_LOOP,
    JC_WAIT_OUT,
    JC_GOTO
  } jump_t;

  typedef struct packed {
    dp_op_t          op;
    jump_t           jc;
    logic [PC_W-1:0] tgt;
    logic            ld_cnt;
  } seq_word_t;

  // Sequencer to datapath
  typedef struct packed {
    dp_op_t op;
    logic   en;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic fresh;
    logic out_free;
  } dp_stat_t;

  // Control store
  function automatic seq_word_t seq_rom(input logic [PC_W-1:0] pc);
    seq_word_t w;
    unique case (pc)
      STEP_IDLE:   w = '{op: OP_LOAD,     jc: JC_WAIT_IN,  tgt: STEP_EXCESS, ld_cnt: 1'b0};
      STEP_EXCESS: w = '{op: OP_EXCESS,   jc: JC_POLL,     tgt: STEP_EMIT,   ld_cnt: 1'b0};
      STEP_MUL_Y:  w = '{op: OP_MUL_Y,    jc: JC_NEXT,     tgt: STEP_IDLE,   ld_cnt: 1'b0};
      STEP_CALC_Y: w = '{op: OP_CALC_Y,   jc: JC_NEXT,     tgt: STEP_IDLE,   ld_cnt: 1'b0};
      STEP_MUL_X:  w = '{op: OP_MUL_X,    jc: JC_NEXT,     tgt: STEP_IDLE,   ld_cnt: 1'b0};
      STEP_DIV_IN: w = '{op: OP_DIV_INIT, jc: JC_NEXT,     tgt: STEP_IDLE,   ld_cnt: 1'b1};
      STEP_DIV:    w = '{op: OP_DIV_STEP, jc: JC_LOOP,     tgt: STEP_DIV,    ld_cnt: 1'b0};
      STEP_CALC_X: w = '{op: OP_CALC_X,   jc: JC_NEXT,     tgt: STEP_IDLE,   ld_cnt: 1'b0};
      STEP_EMIT:   w = '{op: OP_EMIT,     jc: JC_WAIT_OUT, tgt: STEP_IDLE,   ld_cnt: 1'b0};
      default:     w = '{op: OP_NONE,     jc: JC_GOTO,     tgt: STEP_IDLE,   ld_cnt: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tlpp_seq.sv
`default_nettype none

module tlpp_seq
  import tlpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t st,
  output ctl_t          ctl
);

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  seq_word_t        cw;
  logic             en;

  // Current control word
  assign cw = seq_rom(pc_r);

  // Next-step and loop counter logic
  always_comb begin
    pc_nxt  = PC_W'(pc_r + 1'b1);
    cnt_nxt = cnt_r;
    en      = 1'b1;
    unique case (cw.jc)
      JC_NEXT: ;
      JC_WAIT_IN: begin
        en = in_valid;
        if (!in_valid) pc_nxt = pc_r;
      end
      JC_POLL: begin
        if (!st.fresh) pc_nxt = cw.tgt;
      end
      JC_LOOP: begin
        if (cnt_r != '0) begin
          pc_nxt  = cw.tgt;
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
        end
      end
      JC_WAIT_OUT: begin
        en     = st.out_free;
        pc_nxt = st.out_free ? cw.tgt : pc_r;
      end
      JC_GOTO: pc_nxt = cw.tgt;
      default: pc_nxt = STEP_IDLE;
    endcase
    if (cw.ld_cnt) cnt_nxt = CNT_W'(DIV_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= STEP_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Items are taken only at the load step
  assign in_stall = (cw.jc != JC_WAIT_IN);
  assign ctl.op   = cw.op;
  assign ctl.en   = en;

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_LAST)
    else $error("sequencer left its program");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_DIV && cnt_r == '0) |=> pc_r == STEP_CALC_X)
    else $error("divider loop did not exit");

endmodule

`default_nettype wire

>>> rtl/core/tlpp_dp.sv
`default_nettype none

module tlpp_dp
  import tlpp_pkg::*;
#(
  parameter int C_SPAN = C_SPAN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDAT_W-1:0]  cfg_data,
  input  wire logic               in_new_sample,
  input  wire logic [LVL_W-1:0]   in_level_a,
  input  wire logic [LVL_W-1:0]   in_level_b,
  input  wire logic [LVL_W-1:0]   in_level_c,
  input  wire ctl_t               ctl,
  output dp_stat_t                st,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [POSX_W-1:0] out_pos_x,
  output logic signed [POSY_W-1:0] out_pos_y,
  output logic                    out_pressed
);

  localparam int SPAN_SH = $clog2(C_SPAN);
  localparam int YW      = PROD_W + 2;

  // Configuration
  logic [LVL_W-1:0] floor_a_r, floor_b_r, floor_c_r, press_lvl_r;
  logic [SCR_W-1:0] width_r, height_r;

  // Item and working registers
  logic             fresh_r;
  logic [LVL_W-1:0] la_r, lb_r, lc_r;
  logic [LVL_W-1:0] ea_r, eb_r, ec_r;
  logic [SUM_W-1:0] sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0] rem_r;
  logic [SCR_W-1:0] quo_r;
  logic             press_r;

  // Block state
  logic [POSX_W-1:0] latest_x_r, held_x_r;
  logic [POSY_W-1:0] latest_y_r, held_y_r;
  logic              was_pressed_r;

  // Result register
  logic              out_valid_r;
  logic [POSX_W-1:0] out_pos_x_r;
  logic [POSY_W-1:0] out_pos_y_r;
  logic              out_pressed_r;

  logic [LVL_W-1:0]  ea_c, eb_c, ec_c;
  logic [SCR_W-1:0]  mul_a;
  logic [LVL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    trial_diff;
  logic              trial_ge;
  logic [YW-1:0]     y_diff;
  logic [POSY_W-1:0] y_c;
  logic [POSX_W-1:0] x_c;
  logic              emit, hold;

  // Excess over floor
  assign ea_c = (la_r > floor_a_r) ? LVL_W'(la_r - floor_a_r) : '0;
  assign eb_c = (lb_r > floor_b_r) ? LVL_W'(lb_r - floor_b_r) : '0;
  assign ec_c = (lc_r > floor_c_r) ? LVL_W'(lc_r - floor_c_r) : '0;

  // Shared multiplier: height*ec or width*ea
  assign mul_a = (ctl.op == OP_MUL_Y) ? height_r : width_r;
  assign mul_b = (ctl.op == OP_MUL_Y) ? ec_r : ea_r;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Restoring divider step
  assign trial      = {rem_r, quo_r[SCR_W-1]};
  assign trial_diff = trial - {1'b0, sum_r};
  assign trial_ge   = (trial >= {1'b0, sum_r});

  // Vertical position with low saturation
  assign y_diff = YW'(height_r) - YW'(prod_r >> SPAN_SH);
  always_comb begin
    if (ec_r == '0)
      y_c = '1;
    else if (y_diff[YW-1] && !(&y_diff[YW-2:POSY_W-1]))
      y_c = {1'b1, {(POSY_W-1){1'b0}}};
    else
      y_c = y_diff[POSY_W-1:0];
  end

  // Horizontal position
  assign x_c = (ea_r != '0) ? POSX_W'(POSX_W'(width_r) - POSX_W'(quo_r)) : '1;

  assign emit = ctl.en && (ctl.op == OP_EMIT);
  assign hold = press_r || was_pressed_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_a_r   <= FLOOR_RST;
      floor_b_r   <= FLOOR_RST;
      floor_c_r   <= FLOOR_RST;
      press_lvl_r <= PRESS_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FLOOR_A: floor_a_r   <= cfg_data;
        REG_FLOOR_B: floor_b_r   <= cfg_data;
        REG_FLOOR_C: floor_c_r   <= cfg_data;
        REG_PRESS:   press_lvl_r <= cfg_data;
        REG_WIDTH:   width_r     <= cfg_data[SCR_W-1:0];
        REG_HEIGHT:  height_r    <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers, driven by the current op
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      unique case (ctl.op)
        OP_LOAD: begin
          fresh_r <= in_new_sample;
          la_r    <= in_level_a;
          lb_r    <= in_level_b;
          lc_r    <= in_level_c;
        end
        OP_EXCESS: begin
          ea_r    <= ea_c;
          eb_r    <= eb_c;
          ec_r    <= ec_c;
          press_r <= fresh_r &&
                     ((la_r > press_lvl_r) || (lb_r > press_lvl_r) ||
                      (lc_r > press_lvl_r));
        end
        OP_MUL_Y: prod_r <= mul_p;
        OP_MUL_X: begin
          prod_r <= mul_p;
          sum_r  <= SUM_W'(ea_r) + SUM_W'(eb_r);
        end
        OP_DIV_INIT: begin
          rem_r <= SUM_W'(prod_r[PROD_W-1:SCR_W]);
          quo_r <= prod_r[SCR_W-1:0];
        end
        OP_DIV_STEP: begin
          rem_r <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
          quo_r <= {quo_r[SCR_W-2:0], trial_ge};
        end
        default: ;
      endcase
    end
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_x_r    <= '0;
      latest_y_r    <= '0;
      held_x_r      <= '0;
      held_y_r      <= '0;
      was_pressed_r <= 1'b0;
    end else if (ctl.en) begin
      unique case (ctl.op)
        OP_CALC_Y: latest_y_r <= y_c;
        OP_CALC_X: latest_x_r <= x_c;
        OP_EMIT: begin
          if (!hold) begin
            held_x_r <= latest_x_r;
            held_y_r <= latest_y_r;
          end
          was_pressed_r <= press_r;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_x_r   <= hold ? held_x_r : latest_x_r;
      out_pos_y_r   <= hold ? held_y_r : latest_y_r;
      out_pressed_r <= press_r;
    end
  end

  assign st.fresh    = fresh_r;
  assign st.out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_pressed = out_pressed_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && (out_pressed_r == $past(press_r)))
    else $error("emitted item not presented");

  a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !hold) |=> (held_x_r == out_pos_x_r) && (held_y_r == out_pos_y_r))
    else $error("held position does not match unpressed result");

endmodule

`default_nettype wire

>>> rtl/core/three_led_proximity_pointer_unit.sv
`default_nettype none

// Three-channel proximity pointer. Each item carries three proximity levels
// and a fresh-sample flag; each item yields exactly one result: pointer
// position (pos_x, pos_y, -1 for an absent channel) and a press flag. While
// pressed, and on the item after a press, the last unpressed position is
// reported. A small control store steps a shared 10x16 multiplier and a
// restoring divider that resolves one quotient bit per cycle. A fresh sample
// passes the load, excess, Y multiply, Y position, X multiply, divider setup,
// divider loop, X position and emit steps; a plain poll goes from the excess
// step straight to emit, and waits there while a stalled result is held.
// A new item is taken once the previous result is in the output register,
// even while that result is still stalled.
// Configuration writes are always ready and are to be made while idle;
// C_SPAN must be a power of two.

module three_led_proximity_pointer_unit
  import tlpp_pkg::*;
#(
  parameter int C_SPAN = C_SPAN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CDAT_W-1:0]   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_new_sample,
  input  wire logic [LVL_W-1:0]    in_level_a,
  input  wire logic [LVL_W-1:0]    in_level_b,
  input  wire logic [LVL_W-1:0]    in_level_c,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [POSX_W-1:0] out_pos_x,
  output logic signed [POSY_W-1:0] out_pos_y,
  output logic                     out_pressed
);

  ctl_t     ctl;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  // Program sequencer
  tlpp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  // Datapath and registers
  tlpp_dp #(
    .C_SPAN (C_SPAN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_new_sample (in_new_sample),
    .in_level_a    (in_level_a),
    .in_level_b    (in_level_b),
    .in_level_c    (in_level_c),
    .ctl           (ctl),
    .st            (st),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pressed   (out_pressed)
  );

endmodule

`default_nettype wire
